// File: rtl/core/sbfp_pkg.sv
package sbfp_pkg;

   localparam int DATA_BYTES  = 31;
   localparam int FRAME_BYTES = 32;
   localparam int DATA_W      = DATA_BYTES * 8;
   localparam int CNT_W       = 5;
   localparam int CFG_W       = 9;
   localparam int SP_W        = 10;
   localparam int FILL_W      = 10;

   localparam logic [7:0] STROBE_FIRST  = 8'h80;
   localparam logic [7:0] STROBE_SECOND = 8'h40;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic OUT_FRAME = 1'b0;
   localparam logic OUT_FILL  = 1'b1;

   // pending result slots, emitted lowest index first
   localparam int SLOT_PRE0 = 0;
   localparam int SLOT_FRM  = 1;
   localparam int SLOT_FILL = 2;
   localparam int SLOT_PRE1 = 3;
   localparam int SLOTS     = 4;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic              out_kind;
      logic [7:0]        header;
      logic [63:0]       data_a;
      logic [63:0]       data_b;
      logic [63:0]       data_c;
      logic [55:0]       data_d;
      logic [FILL_W-1:0] fill_length;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [SLOTS-1:0]  pend;
      logic [7:0]        hdr;
      logic [DATA_W-1:0] payload;
      logic [FILL_W-1:0] fill_len;
   } desc_type;

endpackage

// File: rtl/core/sector_byte_frame_packer.sv
// channel | dir | handshake            | word
// req     | in  | req_valid/req_stall  | req_type: kind, data_byte
// rsp     | out | rsp_valid/rsp_stall  | rsp_type: frame or fill run, last
// csr     | in  | csr_wr_en            | first_sector_offset, 9 bits
//
// one input word a cycle while req_stall is low; results leave one a cycle
// through the output register while rsp_stall is low; a word causes 0 to 4
// results, so a sector end or end of input holds req while the result slot drains
// reset is synchronous and returns to the no-preamble-sent state
// rsp_stall reaches req_stall combinationally through the result slot
module sector_byte_frame_packer import sbfp_pkg::*; #(
   parameter int SECTOR_BYTES = 512,
   parameter int ALIGN_BYTES  = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic     req_accept;
   desc_type desc;

   assign req_accept = req_valid && !req_stall;

   sbfp_packer #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_packer (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .desc        (desc)
   );

   sbfp_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .desc       (desc),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // a fill run is always followed by a preamble from the same word
   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == OUT_FILL |-> !rsp_data.last)
      else $error("fill run marked last");

   a_fill_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == OUT_FILL |->
         rsp_data.header == '0 && rsp_data.data_a == '0 && rsp_data.data_d == '0)
      else $error("fill run carries frame data");

   a_header_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == OUT_FRAME && rsp_data.header != '0 |->
         (rsp_data.header[7] ^ rsp_data.header[6]) && !rsp_data.header[5] &&
         rsp_data.fill_length == '0)
      else $error("bad frame header");

endmodule

// File: rtl/core/sbfp_packer.sv
module sbfp_packer import sbfp_pkg::*; #(
   parameter int SECTOR_BYTES = 512,
   parameter int ALIGN_BYTES  = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  logic             req_accept,
   input  req_type          req_data,
   output desc_type         desc
);

   localparam int POS_W = $clog2(ALIGN_BYTES);
   localparam logic [POS_W:0] ALIGN_EXT = (POS_W+1)'(ALIGN_BYTES);
   localparam logic [POS_W:0] FRAME_EXT = (POS_W+1)'(FRAME_BYTES);
   localparam logic [SP_W-1:0] SECTOR_V = SP_W'(SECTOR_BYTES);

   logic [CFG_W-1:0]  cfg_ff;
   logic [DATA_W-1:0] store_ff, store_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic              strobe_ff, strobe_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              started_ff, started_in;

   logic [DATA_W-1:0] push;
   logic [CNT_W-1:0]  held1, cnt;
   logic [SP_W-1:0]   sp_base, sp_new;
   logic [POS_W-1:0]  pos_base, p1;
   logic [POS_W:0]    pos_sum, pos_wrap, fill;
   logic              frm, flush;

   always_comb begin
      push     = {store_ff[DATA_W-9:0], req_data.data_byte};
      held1    = held_ff + CNT_W'(1);
      sp_base  = started_ff ? sp_ff : SP_W'(cfg_ff);
      sp_new   = sp_base + SP_W'(1);
      // a fresh stream opens with a preamble, so output is one frame in
      pos_base = started_ff ? pos_ff : POS_W'(FRAME_BYTES);

      if (req_data.kind == KIND_END) begin
         frm   = (held_ff != '0);
         flush = 1'b1;
         cnt   = held_ff;
         desc.payload = store_ff;
      end else begin
         flush = (sp_new >= SECTOR_V);
         frm   = (held1 == CNT_W'(DATA_BYTES)) || flush;
         cnt   = held1;
         desc.payload = push;
      end

      desc.hdr = (strobe_ff ? STROBE_SECOND : STROBE_FIRST) | {3'b000, cnt};

      pos_sum  = {1'b0, pos_base} + FRAME_EXT;
      pos_wrap = (pos_sum >= ALIGN_EXT) ? pos_sum - ALIGN_EXT : pos_sum;
      p1       = frm ? pos_wrap[POS_W-1:0] : pos_base;
      fill     = ALIGN_EXT - {1'b0, p1};
      desc.fill_len = fill[FILL_W-1:0];

      desc.pend = '0;
      desc.pend[SLOT_PRE0] = !started_ff;
      desc.pend[SLOT_FRM]  = frm;
      desc.pend[SLOT_FILL] = flush;
      desc.pend[SLOT_PRE1] = flush;

      if (req_data.kind == KIND_END) begin
         store_in   = '0;
         held_in    = '0;
         strobe_in  = 1'b0;
         sp_in      = '0;
         pos_in     = '0;
         started_in = 1'b0;
      end else begin
         store_in   = frm ? '0 : push;
         held_in    = frm ? '0 : held1;
         strobe_in  = strobe_ff ^ frm;
         sp_in      = flush ? '0 : sp_new;
         // after a flush only the new preamble has gone out
         pos_in     = flush ? POS_W'(FRAME_BYTES) : p1;
         started_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '0;
         store_ff   <= '0;
         held_ff    <= '0;
         strobe_ff  <= 1'b0;
         sp_ff      <= '0;
         pos_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (req_accept) begin
            store_ff   <= store_in;
            held_ff    <= held_in;
            strobe_ff  <= strobe_in;
            sp_ff      <= sp_in;
            pos_ff     <= pos_in;
            started_ff <= started_in;
         end
      end
   end

endmodule

// File: rtl/core/sbfp_sequencer.sv
module sbfp_sequencer import sbfp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_accept,
   input  desc_type desc,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [SLOTS-1:0]  pend_ff, pend_in, first, rest;
   logic [7:0]        hdr_ff;
   logic [DATA_W-1:0] payload_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              out_free, pop;
   logic [CNT_W-1:0]  shift;
   logic [DATA_W-1:0] aligned;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      first    = pend_ff & (~pend_ff + SLOTS'(1));
      rest     = pend_ff & ~first;
      pop      = out_free && (pend_ff != '0);
      pend_in  = pop ? rest : pend_ff;
      // the slot frees once its last result goes out this cycle
      req_stall = (pend_in != '0);

      // partial frame sits right-aligned; the shift moves its oldest byte to data byte 30
      shift   = CNT_W'(DATA_BYTES) - hdr_ff[CNT_W-1:0];
      aligned = payload_ff << {shift, 3'b000};

      rsp_in      = '0;
      rsp_in.last = (rest == '0);
      if (first[SLOT_FRM]) begin
         rsp_in.out_kind = OUT_FRAME;
         rsp_in.header   = hdr_ff;
         rsp_in.data_a   = aligned[63:0];
         rsp_in.data_b   = aligned[127:64];
         rsp_in.data_c   = aligned[191:128];
         rsp_in.data_d   = aligned[247:192];
      end else if (first[SLOT_FILL]) begin
         rsp_in.out_kind    = OUT_FILL;
         rsp_in.fill_length = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= req_accept ? desc.pend : pend_in;
         if (out_free) begin
            rsp_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         hdr_ff     <= desc.hdr;
         payload_ff <= desc.payload;
         fill_ff    <= desc.fill_len;
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
